### sv/fadd_pkg.sv
// fadd_pkg: shared types and constants of the fraction adder
// sequencer states, datapath commands and the status and control structs
// no dependencies
package fadd_pkg;

  localparam int NUM_W = 32;
  localparam int DEN_W = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AD,
    ST_MUL_CB,
    ST_MUL_BD,
    ST_SETUP,
    ST_TWOS,
    ST_XODD,
    ST_REDUCE,
    ST_SCALE,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MUL_AD,
    OP_MUL_CB,
    OP_MUL_BD,
    OP_SETUP,
    OP_TWOS,
    OP_XODD,
    OP_REDUCE,
    OP_SCALE,
    OP_DIV_NUM,
    OP_DIV_DEN,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic both_even;
    logic x_even;
    logic y_zero;
    logic twos_zero;
    logic div_last;
  } status_t;

endpackage

### sv/fadd_if.sv
// fadd_if: request and result channels of the fraction adder
// valid/ready handshake with payload; depends on fadd_pkg
interface fadd_in_if #(parameter int IN_WIDTH = 16);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] num_a;
  logic        [IN_WIDTH-2:0] den_a;
  logic signed [IN_WIDTH-1:0] num_b;
  logic        [IN_WIDTH-2:0] den_b;

  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface fadd_out_if;
  import fadd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] sum_num;
  logic        [DEN_W-1:0] sum_den;

  modport source (output valid, sum_num, sum_den, input ready);
  modport sink   (input valid, sum_num, sum_den, output ready);
endinterface

### sv/fadd_ctrl.sv
// fadd_ctrl: sequencer of the fraction adder
// steps the shared multiplier, subtractor and shifter; depends on fadd_pkg
module fadd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  fadd_pkg::status_t status,
  output fadd_pkg::ctrl_t   ctrl
);
  import fadd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_AD;
      ST_MUL_AD:  state_next = status.den_zero ? ST_DONE : ST_MUL_CB;
      ST_MUL_CB:  state_next = ST_MUL_BD;
      ST_MUL_BD:  state_next = ST_SETUP;
      ST_SETUP:   state_next = status.num_zero ? ST_DONE : ST_TWOS;
      ST_TWOS:    if (!status.both_even) state_next = ST_XODD;
      ST_XODD:    if (!status.x_even) state_next = ST_REDUCE;
      ST_REDUCE:  if (status.y_zero) state_next = ST_SCALE;
      ST_SCALE:   if (status.twos_zero) state_next = ST_DIV_NUM;
      ST_DIV_NUM: if (status.div_last) state_next = ST_DIV_DEN;
      ST_DIV_DEN: if (status.div_last) state_next = ST_DONE;
      ST_DONE:    if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready  = 1'b0;
    ctrl.out_valid = 1'b0;
    ctrl.op        = OP_HOLD;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.op       = OP_LOAD;
      end
      ST_MUL_AD:  ctrl.op = OP_MUL_AD;
      ST_MUL_CB:  ctrl.op = OP_MUL_CB;
      ST_MUL_BD:  ctrl.op = OP_MUL_BD;
      ST_SETUP:   ctrl.op = OP_SETUP;
      ST_TWOS:    ctrl.op = OP_TWOS;
      ST_XODD:    ctrl.op = OP_XODD;
      ST_REDUCE:  ctrl.op = OP_REDUCE;
      ST_SCALE:   ctrl.op = OP_SCALE;
      ST_DIV_NUM: ctrl.op = OP_DIV_NUM;
      ST_DIV_DEN: ctrl.op = OP_DIV_DEN;
      ST_DONE:    ctrl.out_valid = 1'b1;
      default:    ctrl.op = OP_HOLD;
    endcase
  end

endmodule

### sv/fadd_unit.sv
// fadd_unit: datapath of the fraction adder
// one multiplier, subtract/compare logic and single-bit shifters, driven by fadd_ctrl
// depends on fadd_pkg
module fadd_unit #(
  parameter int IN_WIDTH = 16
) (
  input  logic                            clk,
  input  fadd_pkg::op_t                   op,
  input  logic signed [IN_WIDTH-1:0]      num_a,
  input  logic        [IN_WIDTH-2:0]      den_a,
  input  logic signed [IN_WIDTH-1:0]      num_b,
  input  logic        [IN_WIDTH-2:0]      den_b,
  output fadd_pkg::status_t               status,
  output logic signed [fadd_pkg::NUM_W-1:0] sum_num,
  output logic        [fadd_pkg::DEN_W-1:0] sum_den
);
  import fadd_pkg::*;

  localparam int PW  = 2 * IN_WIDTH;
  localparam int MW  = PW - 1;
  localparam int CW  = $clog2(MW);
  localparam int NXW = (MW > NUM_W) ? MW : NUM_W;
  localparam int DXW = (MW > DEN_W) ? MW : DEN_W;

  logic signed [IN_WIDTH-1:0] a_r, c_r;
  logic        [IN_WIDTH-2:0] b_r, d_r;
  logic signed [PW-1:0]       prod, num;
  logic        [MW-1:0]       mag_r, den_r, x, y, rem, dd;
  logic                       neg;
  logic        [CW-1:0]       twos, cnt;

  logic signed [IN_WIDTH-1:0] ma, mb;
  logic signed [PW-1:0]       mul_res, num_abs;
  logic        [MW-1:0]       y_minus_x, x_minus_y, q_next;
  logic                       gcd_borrow, div_borrow;
  logic        [MW:0]         r2;
  logic        [MW-1:0]       div_diff;
  logic        [NXW-1:0]      qn_ext, qn_sgn;
  logic        [DXW-1:0]      qd_ext;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (op)
      OP_MUL_CB: begin
        ma = c_r;
        mb = {1'b0, b_r};
      end
      OP_MUL_BD: begin
        ma = {1'b0, b_r};
        mb = {1'b0, d_r};
      end
      default: begin
        ma = a_r;
        mb = {1'b0, d_r};
      end
    endcase
  end

  assign mul_res = PW'(ma) * PW'(mb);
  assign num_abs = num[PW-1] ? -num : num;

  assign {gcd_borrow, y_minus_x} = {1'b0, y} - {1'b0, x};
  assign x_minus_y = x - y;

  // restoring division step, divisor is the gcd held in x
  assign r2 = {rem, dd[MW-1]};
  assign {div_borrow, div_diff} = (MW+1)'({1'b0, r2} - {2'b0, x});
  assign q_next = {dd[MW-2:0], !div_borrow};

  assign qn_ext = NXW'(q_next);
  assign qn_sgn = neg ? -qn_ext : qn_ext;
  assign qd_ext = DXW'(q_next);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        a_r <= num_a;
        b_r <= den_a;
        c_r <= num_b;
        d_r <= den_b;
      end
      OP_MUL_AD: begin
        prod <= mul_res;
        if (status.den_zero) begin
          sum_num <= '0;
          sum_den <= '0;
        end
      end
      OP_MUL_CB: begin
        num  <= prod;
        prod <= mul_res;
      end
      OP_MUL_BD: begin
        num  <= num + prod;
        prod <= mul_res;
      end
      OP_SETUP: begin
        mag_r <= num_abs[MW-1:0];
        den_r <= prod[MW-1:0];
        x     <= num_abs[MW-1:0];
        y     <= prod[MW-1:0];
        neg   <= num[PW-1];
        twos  <= '0;
        if (status.num_zero) begin
          sum_num <= '0;
          sum_den <= DEN_W'(1);
        end
      end
      OP_TWOS: begin
        if (status.both_even) begin
          x    <= x >> 1;
          y    <= y >> 1;
          twos <= twos + CW'(1);
        end
      end
      OP_XODD: begin
        if (status.x_even) x <= x >> 1;
      end
      OP_REDUCE: begin
        if (!status.y_zero) begin
          if (!y[0]) begin
            y <= y >> 1;
          end else if (gcd_borrow) begin
            x <= y;
            y <= x_minus_y;
          end else begin
            y <= y_minus_x;
          end
        end
      end
      OP_SCALE: begin
        if (status.twos_zero) begin
          rem <= '0;
          dd  <= mag_r;
          cnt <= '0;
        end else begin
          x    <= x << 1;
          twos <= twos - CW'(1);
        end
      end
      OP_DIV_NUM: begin
        if (status.div_last) begin
          sum_num <= qn_sgn[NUM_W-1:0];
          rem     <= '0;
          dd      <= den_r;
          cnt     <= '0;
        end else begin
          rem <= div_borrow ? r2[MW-1:0] : div_diff;
          dd  <= q_next;
          cnt <= cnt + CW'(1);
        end
      end
      OP_DIV_DEN: begin
        if (status.div_last) begin
          sum_den <= qd_ext[DEN_W-1:0];
        end else begin
          rem <= div_borrow ? r2[MW-1:0] : div_diff;
          dd  <= q_next;
          cnt <= cnt + CW'(1);
        end
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.den_zero  = (b_r == '0) || (d_r == '0);
    status.num_zero  = (num == '0);
    status.both_even = !x[0] && !y[0];
    status.x_even    = !x[0];
    status.y_zero    = (y == '0);
    status.twos_zero = (twos == '0);
    status.div_last  = (cnt == CW'(MW - 1));
  end

endmodule

### sv/fraction_add_reduce.sv
// fraction_add_reduce: adds a/b + c/d and returns the sum in lowest terms
// a zero denominator or a zero sum ends early; otherwise the result follows the
// products, the binary gcd steps, the rescale of the gcd and the two restoring divisions;
// one request at a time, the next taken the cycle after the result handshake,
// set by the sequencer stepping the shared datapath
// synchronous rst returns the sequencer to idle
module fraction_add_reduce #(
  parameter int IN_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  fadd_in_if.sink    operands,
  fadd_out_if.source result
);
  import fadd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  fadd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .out_ready (result.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  fadd_unit #(.IN_WIDTH(IN_WIDTH)) u_unit (
    .clk     (clk),
    .op      (ctrl.op),
    .num_a   (operands.num_a),
    .den_a   (operands.den_a),
    .num_b   (operands.num_b),
    .den_b   (operands.den_b),
    .status  (status),
    .sum_num (result.sum_num),
    .sum_den (result.sum_den)
  );

  assign operands.ready = ctrl.in_ready;
  assign result.valid   = ctrl.out_valid;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(operands.ready && result.valid))
    else $error("request taken while a result is pending");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (operands.valid && operands.ready) |=> !operands.ready && !result.valid)
    else $error("sequencer did not start after a request");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready) |=> operands.ready && !result.valid)
    else $error("sequencer did not return to idle");

endmodule
